### design/mdpt_pkg.sv
// Package for the minimum-distance point thinning unit: table depth, widths and
// controller state type. It has no dependencies.
`default_nettype none
package mdpt_pkg;

   localparam int MAX_KEPT = 64;
   localparam int IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W    = $clog2(MAX_KEPT + 1);

   localparam int COORD_W  = 24;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int MD_W     = 8;
   localparam int THR_W    = 4 * MD_W + 16;
   localparam int INDEX_W  = 16;
   localparam int SLOT_W   = 6;
   localparam int KCOUNT_W = 7;

   localparam logic [MD_W-1:0] MIN_DISTANCE_RESET = MD_W'(50);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

### design/min_distance_point_thinning_unit.sv
// Top level of the minimum-distance point thinning unit: kept-point memory,
// scan pipeline and controller. Depends on mdpt_pkg.
//
//   channel   ports                      handshake
//   req       req_* fields               start high while busy low
//   rsp       rsp_* fields               rsp_strobe, one cycle, no stall
//   csr       csr_wr_en, csr_wr_data     written at any enabled edge
//
// A word with an image, from its accept to the next possible accept, takes one memory
// read per stored point, issued once a cycle, then drains the read, difference, square
// and compare pipeline, then decides and writes the new point back and returns to idle.
// With no image or no stored points a word goes straight from its accept to the decide
// step and back to idle.
// Reset clears the kept count and the controller; memory contents are not cleared.
// The receiver cannot stall; the result is registered, so busy falls as it appears.
`default_nettype none
module min_distance_point_thinning_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic                                req_first_point,
   input  wire logic                                req_has_image,
   input  wire logic signed [mdpt_pkg::COORD_W-1:0] req_pos_x,
   input  wire logic signed [mdpt_pkg::COORD_W-1:0] req_pos_y,
   input  wire logic [mdpt_pkg::INDEX_W-1:0]        req_point_index,
   output      logic                                rsp_strobe,
   output      logic                                rsp_accepted,
   output      logic [mdpt_pkg::SLOT_W-1:0]         rsp_slot,
   output      logic [mdpt_pkg::INDEX_W-1:0]        rsp_kept_index,
   output      logic                                rsp_table_full,
   output      logic [mdpt_pkg::KCOUNT_W-1:0]       rsp_kept_count,
   input  wire logic                                csr_wr_en,
   input  wire logic [mdpt_pkg::MD_W-1:0]           csr_wr_data
);

   mdpt_pkg::state_type state_ff, state_in;

   logic [mdpt_pkg::MD_W-1:0]            min_distance_ff;
   logic [mdpt_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [mdpt_pkg::IDX_W-1:0]           scan_ff, scan_in;
   logic signed [mdpt_pkg::COORD_W-1:0]  px_ff, py_ff;
   logic [mdpt_pkg::INDEX_W-1:0]         pidx_ff;
   logic                                 img_ff;
   logic [2*mdpt_pkg::MD_W-1:0]          md_sq_ff;
   logic                                 near_ff, near_in;

   logic [2*mdpt_pkg::COORD_W-1:0]       mem [mdpt_pkg::MAX_KEPT];
   logic [2*mdpt_pkg::COORD_W-1:0]       rd_data_ff;
   logic                                 v1_ff, v2_ff, v3_ff;
   logic signed [mdpt_pkg::DIFF_W-1:0]   dx_ff, dy_ff;
   logic [mdpt_pkg::SQ_W-1:0]            sqx_ff, sqy_ff;

   logic                      rsp_strobe_ff, rsp_accepted_ff, rsp_table_full_ff;
   logic [mdpt_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [mdpt_pkg::INDEX_W-1:0]  rsp_kept_index_ff;
   logic [mdpt_pkg::KCOUNT_W-1:0] rsp_kept_count_ff;

   logic                                 take;
   logic [mdpt_pkg::CNT_W-1:0]           start_count;
   logic                                 scan_en, scan_last, finish, pipe_empty;
   logic                                 table_free, do_store;
   logic [mdpt_pkg::SQ_W:0]              dist_sum;
   logic [mdpt_pkg::SQ_W:0]              thr;
   logic signed [mdpt_pkg::SQ_W-1:0]     prod_x, prod_y;

   assign take        = start && (state_ff == mdpt_pkg::ST_IDLE);
   assign start_count = req_first_point ? '0 : count_ff;
   assign scan_last   = ((mdpt_pkg::CNT_W)'(scan_ff) + (mdpt_pkg::CNT_W)'(1)) == count_ff;
   assign pipe_empty  = !(v1_ff || v2_ff || v3_ff);
   assign table_free  = count_ff < (mdpt_pkg::CNT_W)'(mdpt_pkg::MAX_KEPT);
   assign do_store    = finish && img_ff && !near_ff && table_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mdpt_pkg::ST_IDLE: begin
            if (start) begin
               if (req_has_image && (start_count != '0)) begin
                  state_in = mdpt_pkg::ST_SCAN;
               end else begin
                  state_in = mdpt_pkg::ST_FINISH;
               end
            end
         end
         mdpt_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = mdpt_pkg::ST_DRAIN;
            end
         end
         mdpt_pkg::ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = mdpt_pkg::ST_FINISH;
            end
         end
         mdpt_pkg::ST_FINISH: begin
            state_in = mdpt_pkg::ST_IDLE;
         end
         default: state_in = mdpt_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      scan_en = 1'b0;
      finish  = 1'b0;
      busy    = 1'b1;
      unique case (state_ff)
         mdpt_pkg::ST_IDLE:   busy    = 1'b0;
         mdpt_pkg::ST_SCAN:   scan_en = 1'b1;
         mdpt_pkg::ST_DRAIN:  ;
         mdpt_pkg::ST_FINISH: finish  = 1'b1;
         default:             busy    = 1'b0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (take) begin
         count_in = start_count;
      end else if (do_store) begin
         count_in = count_ff + (mdpt_pkg::CNT_W)'(1);
      end
      scan_in = take ? '0 : (scan_en ? scan_ff + (mdpt_pkg::IDX_W)'(1) : scan_ff);
      thr      = (mdpt_pkg::SQ_W + 1)'({md_sq_ff, 16'b0});
      dist_sum = (mdpt_pkg::SQ_W + 1)'(sqx_ff) + (mdpt_pkg::SQ_W + 1)'(sqy_ff);
      near_in = near_ff;
      if (take) begin
         near_in = 1'b0;
      end else if (v3_ff && (dist_sum < thr)) begin
         near_in = 1'b1;
      end
      prod_x = (mdpt_pkg::SQ_W)'(dx_ff) * (mdpt_pkg::SQ_W)'(dx_ff);
      prod_y = (mdpt_pkg::SQ_W)'(dy_ff) * (mdpt_pkg::SQ_W)'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mdpt_pkg::ST_IDLE;
         min_distance_ff <= mdpt_pkg::MIN_DISTANCE_RESET;
         count_ff        <= '0;
         near_ff         <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            min_distance_ff <= csr_wr_data;
         end
         count_ff      <= count_in;
         near_ff       <= near_in;
         v1_ff         <= scan_en;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         rsp_strobe_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (take) begin
         px_ff    <= req_pos_x;
         py_ff    <= req_pos_y;
         pidx_ff  <= req_point_index;
         img_ff   <= req_has_image;
         md_sq_ff <= (2 * mdpt_pkg::MD_W)'(min_distance_ff)
                     * (2 * mdpt_pkg::MD_W)'(min_distance_ff);
      end
      dx_ff  <= (mdpt_pkg::DIFF_W)'(px_ff) - (mdpt_pkg::DIFF_W)'(
                   $signed(rd_data_ff[2*mdpt_pkg::COORD_W-1:mdpt_pkg::COORD_W]));
      dy_ff  <= (mdpt_pkg::DIFF_W)'(py_ff) - (mdpt_pkg::DIFF_W)'(
                   $signed(rd_data_ff[mdpt_pkg::COORD_W-1:0]));
      sqx_ff <= (mdpt_pkg::SQ_W)'(prod_x);
      sqy_ff <= (mdpt_pkg::SQ_W)'(prod_y);
      if (finish) begin
         rsp_accepted_ff   <= do_store;
         rsp_table_full_ff <= img_ff && !near_ff && !table_free;
         rsp_slot_ff       <= do_store ? (mdpt_pkg::SLOT_W)'(count_ff) : '0;
         rsp_kept_index_ff <= do_store ? pidx_ff : '0;
         rsp_kept_count_ff <= (mdpt_pkg::KCOUNT_W)'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         mem[count_ff[mdpt_pkg::IDX_W-1:0]] <= {px_ff, py_ff};
      end
      if (scan_en) begin
         rd_data_ff <= mem[scan_ff];
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_kept_index = rsp_kept_index_ff;
   assign rsp_table_full = rsp_table_full_ff;
   assign rsp_kept_count = rsp_kept_count_ff;

endmodule
`default_nettype wire
